>>> rtl/core/upsa_pkg.sv
// Shared types, constants and helper functions for the pin scan announcer.
`default_nettype none

package upsa_pkg;

   // Scan table and message layout
   localparam int PIN_COUNT    = 8;
   localparam int PIN_IDX_W    = 3;
   localparam int MSG_LEN      = 16;
   localparam int BITS_PER_CHR = 10;

   // Field widths
   localparam int TIME_W  = 12;
   localparam int FRAC_W  = 8;
   localparam int PIN_W   = 5;
   localparam int SYNC_W  = 16;
   localparam int PASS_W  = 4;
   localparam int CHAR_W  = 4;
   localparam int BIT_W   = 4;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 16;

   // Configuration register indexes
   typedef enum logic [CSR_A_W-1:0] {
      CSR_SCAN_ENABLE   = 3'd0,
      CSR_SYNCS_PER_PIN = 3'd1,
      CSR_PASS_LIMIT    = 3'd2,
      CSR_BIT_WHOLE_US  = 3'd3,
      CSR_BIT_FRAC_STEP = 3'd4,
      CSR_BIT_FRAC_MOD  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              scan_enable;
      logic [SYNC_W-1:0] syncs_per_pin;
      logic [PASS_W-1:0] pass_limit;
      logic [7:0]        bit_whole_us;
      logic [7:0]        bit_frac_step;
      logic [7:0]        bit_frac_modulus;
   } cfg_type;

   typedef struct packed {
      logic             drive_enable;
      logic             line_level;
      logic [PIN_W-1:0] pin_number;
      logic             scanning;
      logic             scan_finished;
   } result_type;

   typedef struct packed {
      logic [TIME_W-1:0] edge_time;
      logic [FRAC_W-1:0] frac_acc;
   } edge_type;

   // Pin numbers visited in scan order
   function automatic logic [PIN_W-1:0] pin_lookup(input logic [PIN_IDX_W-1:0] idx);
      logic [PIN_W-1:0] pin;
      case (idx)
         3'd0:    pin = 5'd28;
         3'd1:    pin = 5'd29;
         3'd2:    pin = 5'd22;
         3'd3:    pin = 5'd23;
         3'd4:    pin = 5'd24;
         3'd5:    pin = 5'd25;
         3'd6:    pin = 5'd26;
         default: pin = 5'd27;
      endcase
      return pin;
   endfunction

   // Character k of the announcement; the pin goes out as two decimal digits
   function automatic logic [7:0] char_code(input logic [CHAR_W-1:0] k,
                                            input logic [PIN_W-1:0]  pin);
      logic [1:0]       tens;
      logic [PIN_W-1:0] ones;
      logic [7:0]       code;
      tens = (pin >= 5'd30) ? 2'd3 : (pin >= 5'd20) ? 2'd2 : (pin >= 5'd10) ? 2'd1 : 2'd0;
      ones = pin - ({3'd0, tens} * 5'd10);
      case (k)
         4'd0:    code = 8'h0D;
         4'd1:    code = 8'h0A;
         4'd2:    code = 8'h55;
         4'd3:    code = 8'h45;
         4'd4:    code = 8'h58;
         4'd5:    code = 8'h54;
         4'd6:    code = 8'h20;
         4'd7:    code = 8'h47;
         4'd8:    code = 8'h50;
         4'd9:    code = 8'h49;
         4'd10:   code = 8'h4F;
         4'd11:   code = 8'h3D;
         4'd12:   code = 8'h30 + {6'd0, tens};
         4'd13:   code = 8'h30 + {3'd0, ones};
         4'd14:   code = 8'h0D;
         default: code = 8'h0A;
      endcase
      return code;
   endfunction

   // Bit n of the 8N1 frame: start 0, data LSB first, stop 1
   function automatic logic frame_bit(input logic [CHAR_W-1:0] k,
                                      input logic [BIT_W-1:0]  n,
                                      input logic [PIN_W-1:0]  pin);
      logic [15:0] frame;
      frame = {6'd0, 1'b1, char_code(k, pin), 1'b0};
      return frame[n];
   endfunction

   // Move the bit edge by one period, carrying the fraction into a microsecond
   function automatic edge_type advance_edge(input logic [TIME_W-1:0] edge_time,
                                             input logic [FRAC_W-1:0] frac_acc,
                                             input cfg_type           cfg);
      logic [FRAC_W:0] f;
      logic            carry;
      edge_type        res;
      f     = {1'b0, frac_acc} + {1'b0, cfg.bit_frac_step};
      carry = (f >= {1'b0, cfg.bit_frac_modulus});
      if (carry) begin
         f = f - {1'b0, cfg.bit_frac_modulus};
      end
      res.frac_acc  = f[FRAC_W-1:0];
      res.edge_time = edge_time + {4'd0, cfg.bit_whole_us} + {11'd0, carry};
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/uart_pin_scan_announcer_top.sv
// Pin scan announcer: stream ports, configuration registers and result register.
// The result of a transfer appears on rsp_ in the cycle after it is accepted.
// Throughput: one transfer per cycle while the result register is free or being drained; the state
//   update and next result come from one pass of logic between the state registers and the result register.
// Reset: synchronous; clears scan state, empties the result register and loads the
//   configuration defaults (scan off, 95 syncs per pin, 4 passes, 8 49/72 us per bit).
`default_nettype none

module uart_pin_scan_announcer_top
   import upsa_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire  [7:0]         req_tdata,   // [0] us_tick, [1] sync_pulse
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [15:0]        rsp_tdata,   // [0] drive_enable, [1] line_level,
                                           // [6:2] pin_number, [7] scanning,
                                           // [8] scan_finished
   input  wire                csr_we,
   input  wire  [CSR_A_W-1:0] csr_addr,
   input  wire  [CSR_D_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       req_xfer;

   // Accept when the result register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   upsa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (req_xfer),
      .us_tick    (req_tdata[0]),
      .sync_pulse (req_tdata[1]),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_enable      <= 1'b0;
         cfg_ff.syncs_per_pin    <= 16'd95;
         cfg_ff.pass_limit       <= 4'd4;
         cfg_ff.bit_whole_us     <= 8'd8;
         cfg_ff.bit_frac_step    <= 8'd49;
         cfg_ff.bit_frac_modulus <= 8'd72;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SCAN_ENABLE:   cfg_ff.scan_enable      <= csr_wdata[0];
            CSR_SYNCS_PER_PIN: cfg_ff.syncs_per_pin    <= csr_wdata;
            CSR_PASS_LIMIT:    cfg_ff.pass_limit       <= csr_wdata[PASS_W-1:0];
            CSR_BIT_WHOLE_US:  cfg_ff.bit_whole_us     <= csr_wdata[7:0];
            CSR_BIT_FRAC_STEP: cfg_ff.bit_frac_step    <= csr_wdata[7:0];
            CSR_BIT_FRAC_MOD:  cfg_ff.bit_frac_modulus <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Result register: load on accept, drop on output transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_data_ff.scan_finished,
                        rsp_data_ff.scanning,
                        rsp_data_ff.pin_number,
                        rsp_data_ff.line_level,
                        rsp_data_ff.drive_enable};

endmodule

`default_nettype wire

>>> rtl/core/upsa_core.sv
// Scan state and serial bit timing; computes the next state and the result per transfer.
`default_nettype none

module upsa_core
   import upsa_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        step,
   input  wire        us_tick,
   input  wire        sync_pulse,
   input  cfg_type    cfg,
   output result_type result
);

   logic [SYNC_W-1:0]    sync_count_ff,  sync_count_in;
   logic [PIN_IDX_W-1:0] pin_index_ff,   pin_index_in;
   logic [PASS_W-1:0]    pass_count_ff,  pass_count_in;
   logic                 scan_done_ff,   scan_done_in;
   logic                 announcing_ff,  announcing_in;
   logic [CHAR_W-1:0]    char_index_ff,  char_index_in;
   logic [BIT_W-1:0]     bit_index_ff,   bit_index_in;
   logic [TIME_W-1:0]    elapsed_us_ff,  elapsed_us_in;
   logic [TIME_W-1:0]    edge_time_ff,   edge_time_in;
   logic [FRAC_W-1:0]    frac_acc_ff,    frac_acc_in;
   logic [PIN_W-1:0]     current_pin_ff, current_pin_in;
   logic                 level_ff,       level_in;

   logic                 finished;
   logic                 active;
   logic                 drive;
   edge_type             adv_cur;
   edge_type             adv_zero;
   logic [TIME_W-1:0]    elapsed;
   logic [BIT_W-1:0]     bit_next;
   logic [CHAR_W:0]      char_next;
   logic [PIN_IDX_W+1:0] pin_next;
   logic [PASS_W:0]      pass_next;
   logic [SYNC_W:0]      sync_next;

   assign adv_cur  = advance_edge(edge_time_ff, frac_acc_ff, cfg);
   assign adv_zero = advance_edge('0, '0, cfg);

   // Next scan and bit timing state
   always_comb begin
      sync_count_in  = sync_count_ff;
      pin_index_in   = pin_index_ff;
      pass_count_in  = pass_count_ff;
      scan_done_in   = scan_done_ff;
      announcing_in  = announcing_ff;
      char_index_in  = char_index_ff;
      bit_index_in   = bit_index_ff;
      elapsed_us_in  = elapsed_us_ff;
      edge_time_in   = edge_time_ff;
      frac_acc_in    = frac_acc_ff;
      current_pin_in = current_pin_ff;
      level_in       = level_ff;
      finished       = 1'b0;
      elapsed        = elapsed_us_ff + {{(TIME_W-1){1'b0}}, us_tick};
      bit_next       = bit_index_ff + 4'd1;
      char_next      = {1'b0, char_index_ff} + 5'd1;
      pin_next       = {2'b00, pin_index_ff} + 5'd1;
      pass_next      = {1'b0, pass_count_ff} + 5'd1;
      sync_next      = {1'b0, sync_count_ff} + 17'd1;

      if (step && cfg.scan_enable && !scan_done_ff) begin
         if (announcing_ff) begin
            elapsed_us_in = elapsed;
            if (elapsed >= edge_time_ff) begin
               if (bit_next >= BIT_W'(BITS_PER_CHR)) begin
                  if (char_next >= (CHAR_W+1)'(MSG_LEN)) begin
                     // Last stop bit done: release the pin, step to the next one
                     announcing_in = 1'b0;
                     char_index_in = '0;
                     bit_index_in  = '0;
                     level_in      = 1'b1;
                     if (pin_next >= (PIN_IDX_W+2)'(PIN_COUNT) || pin_next[PIN_IDX_W]) begin
                        pin_index_in  = '0;
                        pass_count_in = pass_next[PASS_W-1:0];
                        if (pass_next >= {1'b0, cfg.pass_limit}) begin
                           scan_done_in = 1'b1;
                           finished     = 1'b1;
                        end
                     end else begin
                        pin_index_in = pin_next[PIN_IDX_W-1:0];
                     end
                  end else begin
                     // Next character starts with its start bit
                     char_index_in = char_next[CHAR_W-1:0];
                     bit_index_in  = '0;
                     elapsed_us_in = '0;
                     level_in      = frame_bit(char_next[CHAR_W-1:0], '0, current_pin_ff);
                     edge_time_in  = adv_zero.edge_time;
                     frac_acc_in   = adv_zero.frac_acc;
                  end
               end else begin
                  bit_index_in = bit_next;
                  level_in     = frame_bit(char_index_ff, bit_next, current_pin_ff);
                  edge_time_in = adv_cur.edge_time;
                  frac_acc_in  = adv_cur.frac_acc;
               end
            end
         end else if (sync_pulse) begin
            if (sync_next >= {1'b0, cfg.syncs_per_pin}) begin
               // Open an announcement on the next table pin
               sync_count_in  = '0;
               current_pin_in = pin_lookup(pin_index_ff);
               announcing_in  = 1'b1;
               char_index_in  = '0;
               bit_index_in   = '0;
               elapsed_us_in  = '0;
               level_in       = frame_bit('0, '0, current_pin_ff);
               edge_time_in   = adv_zero.edge_time;
               frac_acc_in    = adv_zero.frac_acc;
            end else begin
               sync_count_in = sync_next[SYNC_W-1:0];
            end
         end
      end
   end

   // Result seen after this transfer's update
   always_comb begin
      active                = cfg.scan_enable && !scan_done_in;
      drive                 = active && announcing_in;
      result.drive_enable   = drive;
      result.line_level     = drive ? level_in : 1'b1;
      result.pin_number     = current_pin_in;
      result.scanning       = active;
      result.scan_finished  = finished;
   end

   // Hold state between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_count_ff  <= '0;
         pin_index_ff   <= '0;
         pass_count_ff  <= '0;
         scan_done_ff   <= 1'b0;
         announcing_ff  <= 1'b0;
         char_index_ff  <= '0;
         bit_index_ff   <= '0;
         elapsed_us_ff  <= '0;
         edge_time_ff   <= '0;
         frac_acc_ff    <= '0;
         current_pin_ff <= '0;
         level_ff       <= 1'b1;
      end else begin
         sync_count_ff  <= sync_count_in;
         pin_index_ff   <= pin_index_in;
         pass_count_ff  <= pass_count_in;
         scan_done_ff   <= scan_done_in;
         announcing_ff  <= announcing_in;
         char_index_ff  <= char_index_in;
         bit_index_ff   <= bit_index_in;
         elapsed_us_ff  <= elapsed_us_in;
         edge_time_ff   <= edge_time_in;
         frac_acc_ff    <= frac_acc_in;
         current_pin_ff <= current_pin_in;
         level_ff       <= level_in;
      end
   end

endmodule

`default_nettype wire
